/* rtl/biquad_iir_filter_macros.svh */
// ----------------------------------------------------------------------------
// biquad iir filter assertion macros
// concurrent property wrappers shared by the filter rtl
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BQF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// next-cycle implication, disabled during reset
`define BQF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`endif

/* rtl/bqf_pkg.sv */
// ----------------------------------------------------------------------------
// bqf_pkg
// shared types and constants of the biquad iir filter
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

    // five gains, each split into a low and a high half
    localparam int MAC_STEPS = 10;
    localparam int STEP_BITS = 4;

    typedef enum logic [2:0] {
        CFG_FF0 = 3'd0,
        CFG_FF1 = 3'd1,
        CFG_FF2 = 3'd2,
        CFG_FB1 = 3'd3,
        CFG_FB2 = 3'd4,
        CFG_DIV = 3'd5
    } t_cfg_index;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAC  = 5'b00010,
        ST_MAGN = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic                 load;
        logic                 mac_mul;
        logic                 mac_add;
        logic [STEP_BITS-1:0] mac_step;
        logic                 div_init;
        logic                 div_step;
        logic                 commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/bqf_ctrl.sv */
// ----------------------------------------------------------------------------
// bqf_ctrl
// sequencer for the multiply-accumulate, divide and commit phases
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_ctrl
    import bqf_pkg::*;
#(
    parameter int ACC_BITS = 51
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd
);

    localparam int CNT_BITS = $clog2(ACC_BITS);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.mac_step = r_cnt[STEP_BITS-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mac_mul = (r_cnt < CNT_BITS'(MAC_STEPS));
                o_cmd.mac_add = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(MAC_STEPS)) begin
                    n_cnt   = '0;
                    n_state = ST_MAGN;
                end
            end
            ST_MAGN: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(ACC_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/bqf_datapath.sv */
// ----------------------------------------------------------------------------
// bqf_datapath
// shared multiplier, accumulator, serial divider, saturation and delay lines
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_datapath
    import bqf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 32,
    parameter int ACC_BITS    = 51
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic [COEF_BITS-1:0]          i_ff0,
    input  wire logic [COEF_BITS-1:0]          i_ff1,
    input  wire logic [COEF_BITS-1:0]          i_ff2,
    input  wire logic [COEF_BITS-1:0]          i_fb1,
    input  wire logic [COEF_BITS-1:0]          i_fb2,
    input  wire logic [COEF_BITS-2:0]          i_div,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out
);

    localparam int LO_BITS  = COEF_BITS / 2;
    localparam int HI_BITS  = COEF_BITS - LO_BITS;
    localparam int OPB_BITS = HI_BITS + 1;
    localparam int PRD_BITS = SAMPLE_BITS + OPB_BITS;
    localparam int EXT_BITS = SAMPLE_BITS + COEF_BITS + 1;
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0] r_x, r_xd1, r_xd2, r_yd1, r_yd2;
    logic signed [PRD_BITS-1:0]    r_prod;
    logic                          r_prod_hi;
    logic [ACC_BITS-1:0]           r_acc;
    logic [ACC_BITS-1:0]           r_quo;
    logic [COEF_BITS-2:0]          r_rem;
    logic                          r_neg;
    logic                          r_zero;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;

    logic [2:0]                    term;
    logic signed [SAMPLE_BITS-1:0] mult_a;
    logic [COEF_BITS-1:0]          coef_sel;
    logic signed [OPB_BITS-1:0]    mult_b;
    logic signed [PRD_BITS-1:0]    prod_full;
    logic signed [EXT_BITS-1:0]    prod_ext;
    logic signed [EXT_BITS-1:0]    prod_shf;
    logic [ACC_BITS-1:0]           acc_term;
    logic [ACC_BITS-1:0]           mag;
    logic [COEF_BITS-1:0]          shifted;
    logic [COEF_BITS-1:0]          diff;
    logic                          ge;
    logic                          sat;
    logic [SAMPLE_BITS-1:0]        q_lo;
    logic [SAMPLE_BITS-1:0]        res;

    // operand select: term from step bits above, half from step bit zero
    assign term = i_cmd.mac_step[STEP_BITS-1:1];

    always_comb begin
        case (term)
            3'd0:    begin mult_a = r_x;   coef_sel = i_ff0; end
            3'd1:    begin mult_a = r_xd1; coef_sel = i_ff1; end
            3'd2:    begin mult_a = r_xd2; coef_sel = i_ff2; end
            3'd3:    begin mult_a = r_yd1; coef_sel = i_fb1; end
            3'd4:    begin mult_a = r_yd2; coef_sel = i_fb2; end
            default: begin mult_a = '0;    coef_sel = '0;    end
        endcase
    end

    always_comb begin
        if (i_cmd.mac_step[0]) begin
            mult_b = OPB_BITS'($signed(coef_sel[COEF_BITS-1:LO_BITS]));
        end else begin
            mult_b = OPB_BITS'({1'b0, coef_sel[LO_BITS-1:0]});
        end
    end

    assign prod_full = mult_a * mult_b;

    // align partial product and fold into accumulator width
    assign prod_ext = EXT_BITS'(r_prod);
    assign prod_shf = r_prod_hi ? (prod_ext <<< LO_BITS) : prod_ext;
    assign acc_term = ACC_BITS'(prod_shf);

    assign mag = r_acc[ACC_BITS-1] ? (ACC_BITS'(0) - r_acc) : r_acc;

    // restoring divide, one quotient bit per step
    assign shifted = {r_rem, r_quo[ACC_BITS-1]};
    assign diff    = shifted - {1'b0, i_div};
    assign ge      = (shifted >= {1'b0, i_div});

    assign sat  = |r_quo[ACC_BITS-1:SAMPLE_BITS-1];
    assign q_lo = r_quo[SAMPLE_BITS-1:0];

    always_comb begin
        if (r_zero) begin
            res = '0;
        end else if (r_neg) begin
            res = sat ? S_MIN : (SAMPLE_BITS'(0) - q_lo);
        end else begin
            res = sat ? S_MAX : q_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_sample_in;
            r_acc <= '0;
        end else if (i_cmd.mac_add) begin
            r_acc <= r_acc + acc_term;
        end
        if (i_cmd.mac_mul) begin
            r_prod    <= prod_full;
            r_prod_hi <= i_cmd.mac_step[0];
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_acc[ACC_BITS-1];
            r_zero <= (r_acc == '0);
            r_quo  <= mag;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[ACC_BITS-2:0], ge};
            r_rem <= ge ? diff[COEF_BITS-2:0] : shifted[COEF_BITS-2:0];
        end
        if (i_cmd.commit) begin
            r_sample_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xd1 <= '0;
            r_xd2 <= '0;
            r_yd1 <= '0;
            r_yd2 <= '0;
        end else if (i_cmd.commit) begin
            r_xd1 <= r_x;
            r_xd2 <= r_xd1;
            r_yd1 <= res;
            r_yd2 <= r_yd1;
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

`default_nettype wire

/* rtl/biquad_iir_filter.sv */
// ----------------------------------------------------------------------------
// biquad_iir_filter
// direct form I biquad section with configurable gains and divisor
// ----------------------------------------------------------------------------
// usage:
//   input channel  i_in_valid / o_in_stall carries i_sample_in; a request is
//   taken when valid is high and stall is low
//   output channel o_out_valid / i_out_stall carries o_sample_out from an
//   output register; it may hold a result while the next sample is taken
//   config port    i_cfg_we / i_cfg_index / i_cfg_data, written while idle
//   sequence       load, ten partial products accumulated on the shared
//                  multiplier, magnitude, ACC_BITS quotient bits on the
//                  bit-serial divider (ACC_BITS = 51 at default sizes), commit
//   input side     the next sample is not taken until the current one has
//                  been committed and the sequencer is back in idle
//   stall          a result waiting in the output register holds the next
//                  commit until it is taken
//   reset          clears delay lines and handshake state, loads unity gain
//                  on the current sample and a unity divisor
// ----------------------------------------------------------------------------
`default_nettype none

`include "biquad_iir_filter_macros.svh"

module biquad_iir_filter
    import bqf_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 32,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [COEF_BITS-1:0]          i_cfg_data
);

    localparam int ACC_FULL = SAMPLE_BITS + COEF_BITS + 3;
    localparam int ACC_BITS = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam logic [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic [COEF_BITS-1:0] r_ff0, r_ff1, r_ff2, r_fb1, r_fb2;
    logic [COEF_BITS-2:0] r_div;
    t_dp_cmd              cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff0 <= UNITY;
            r_ff1 <= '0;
            r_ff2 <= '0;
            r_fb1 <= '0;
            r_fb2 <= '0;
            r_div <= UNITY[COEF_BITS-2:0];
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FF0: r_ff0 <= i_cfg_data;
                CFG_FF1: r_ff1 <= i_cfg_data;
                CFG_FF2: r_ff2 <= i_cfg_data;
                CFG_FB1: r_fb1 <= i_cfg_data;
                CFG_FB2: r_fb2 <= i_cfg_data;
                CFG_DIV: r_div <= i_cfg_data[COEF_BITS-2:0];
                default: ;
            endcase
        end
    end

    bqf_ctrl #(
        .ACC_BITS (ACC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bqf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample_in  (i_sample_in),
        .i_ff0        (r_ff0),
        .i_ff1        (r_ff1),
        .i_ff2        (r_ff2),
        .i_fb1        (r_fb1),
        .i_fb2        (r_fb2),
        .i_div        (r_div),
        .o_sample_out (o_sample_out)
    );

    // a taken request keeps the input side busy while it is computed
    `BQF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a new result appears only as the sequencer returns to idle
    `BQF_ASSERT_NOW(a_result_at_idle, i_clk, i_rst_n, $rose(o_out_valid), $fell(o_in_stall))
    // finishing a request always leaves a result on the output
    `BQF_ASSERT_NOW(a_idle_has_result, i_clk, i_rst_n, $fell(o_in_stall), o_out_valid)

endmodule

`default_nettype wire
